>>> hw/rtl/odss_pkg.sv
// ----------------------------------------------------------------------------
// odss_pkg: shared types and constants of the spiral ordered-dither screen
// Field widths, command codes and the queued command format.
// ----------------------------------------------------------------------------
package odss_pkg;

    localparam int MAX_SIDE = 16;                       // largest screen side
    localparam int SIDE_W   = 5;                        // holds 1 .. MAX_SIDE
    localparam int IDX_W    = 4;                        // one screen coordinate
    localparam int ADDR_W   = 2 * IDX_W;                // {first, second} index
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ENTRY_W  = 9;                        // ranks 1 .. 256
    localparam int COORD_W  = 12;
    localparam int CH_W     = 8;
    localparam int IN_W     = 2 * COORD_W + 3 * CH_W;   // 48, whole bytes
    localparam int OUT_W    = 3 * CH_W;                 // 24, whole bytes

    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd4;
    localparam logic [CH_W-1:0]   CH_ON      = 8'hFF;
    localparam logic [CH_W-1:0]   CH_OFF     = 8'h00;

    localparam logic MODE_REBUILD = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] col_x;
        logic [COORD_W-1:0] row_y;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
    } t_cmd;

endpackage

>>> hw/rtl/odss_ram.sv
// ----------------------------------------------------------------------------
// odss_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module odss_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/odss_front.sv
// ----------------------------------------------------------------------------
// odss_front: input side of the dither screen
// Unpacks input beats into commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module odss_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [odss_pkg::IN_W-1:0]     i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output odss_pkg::t_cmd                o_cmd
);

    localparam int CW = odss_pkg::COORD_W;
    localparam int HW = odss_pkg::CH_W;

    odss_pkg::t_cmd r_q [2];
    odss_pkg::t_cmd w_in;
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    // decode the beat into a command
    always_comb begin
        w_in.mode  = i_s_tuser[0];
        w_in.col_x = i_s_tdata[CW-1:0];
        w_in.row_y = i_s_tdata[2*CW-1:CW];
        w_in.red   = i_s_tdata[2*CW+HW-1:2*CW];
        w_in.green = i_s_tdata[2*CW+2*HW-1:2*CW+HW];
        w_in.blue  = i_s_tdata[2*CW+3*HW-1:2*CW+2*HW];
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

endmodule

>>> hw/rtl/odss_back.sv
// ----------------------------------------------------------------------------
// odss_back: execution side of the dither screen
// Spiral walk that fills the screen RAM, pixel modulo/lookup/compare path,
// and the output register.
// ----------------------------------------------------------------------------
module odss_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [odss_pkg::SIDE_W-1:0]    i_matrix_size,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  odss_pkg::t_cmd                 i_cmd,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [odss_pkg::OUT_W-1:0]     o_m_tdata,
    output logic [0:0]                     o_m_tuser
);

    localparam int SW = odss_pkg::SIDE_W;
    localparam int IW = odss_pkg::IDX_W;
    localparam int AW = odss_pkg::ADDR_W;
    localparam int EW = odss_pkg::ENTRY_W;
    localparam int HW = odss_pkg::CH_W;
    localparam int PW = HW + 2 * SW - 1;   // channel * (n*n+1), 17 bits
    localparam int KW = 2 * SW - 1;        // n*n, 9 bits

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_MOD  = 5'b00100,
        S_READ = 5'b01000,
        S_CALC = 5'b10000
    } t_state;

    // (rem*16 + nib) mod side, one bit per restoring step
    function automatic logic [IW-1:0] f_mod_nib(input logic [IW-1:0] rem,
                                                input logic [IW-1:0] nib,
                                                input logic [SW-1:0] side);
        logic [SW-1:0] t;
        t = {1'b0, rem};
        for (int b = IW - 1; b >= 0; b--) begin
            t = {t[IW-1:0], nib[b]};
            if (t >= side) begin
                t = t - side;
            end
        end
        return t[IW-1:0];
    endfunction

    t_state          r_state, n_state;
    odss_pkg::t_cmd  r_cmd, n_cmd;
    logic [SW-1:0]   r_side, n_side;
    logic            r_built, n_built;
    logic [IW-1:0]   r_row, n_row;
    logic [IW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_k, n_k;
    logic [EW-1:0]   r_rank, n_rank;
    logic [SW-1:0]   r_leg, n_leg;
    logic [SW-1:0]   r_step, n_step;
    logic            r_col_leg, n_col_leg;
    logic            r_fwd, n_fwd;
    logic [1:0]      r_mcnt, n_mcnt;
    logic [IW-1:0]   r_xm, n_xm;
    logic [IW-1:0]   r_ym, n_ym;
    logic [PW-1:0]   r_prod [3];
    logic            r_out_valid, n_out_valid;
    logic [HW-1:0]   r_out_r, r_out_g, r_out_b;
    logic            r_out_user;
    logic            w_load;

    logic [KW-1:0]   w_size;
    logic [KW-1:0]   w_scale;
    logic [KW-1:0]   w_half;
    logic [AW-1:0]   w_last;
    logic [AW-1:0]   w_half_m1;
    logic [SW-1:0]   w_clamp;
    logic [IW-1:0]   w_xnib, w_ynib;
    logic [PW-1:0]   w_thr;
    logic [EW-1:0]   w_entry;
    logic            w_we;

    // screen geometry from the side in use
    assign w_size    = KW'(r_side) * KW'(r_side);
    assign w_scale   = w_size + KW'(1);
    assign w_half    = KW'(({1'b0, w_size} + {{KW{1'b0}}, 1'b1}) >> 1);
    assign w_last    = AW'(w_size - KW'(1));
    assign w_half_m1 = AW'(w_half - KW'(1));
    assign w_thr     = {w_entry, {HW{1'b0}}};

    always_comb begin
        if (i_matrix_size == '0) begin
            w_clamp = SW'(1);
        end else if (i_matrix_size > SW'(odss_pkg::MAX_SIDE)) begin
            w_clamp = SW'(odss_pkg::MAX_SIDE);
        end else begin
            w_clamp = i_matrix_size;
        end
    end

    always_comb begin
        case (r_mcnt)
            2'd0: begin
                w_xnib = r_cmd.col_x[11:8];
                w_ynib = r_cmd.row_y[11:8];
            end
            2'd1: begin
                w_xnib = r_cmd.col_x[7:4];
                w_ynib = r_cmd.row_y[7:4];
            end
            default: begin
                w_xnib = r_cmd.col_x[3:0];
                w_ynib = r_cmd.row_y[3:0];
            end
        endcase
    end

    odss_ram #(
        .WIDTH (EW),
        .DEPTH (odss_pkg::DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_col, r_row}),
        .i_wdata (r_rank),
        .i_raddr ({r_xm, r_ym}),
        .o_rdata (w_entry)
    );

    assign w_load = (r_state == S_CALC) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_side      = r_side;
        n_built     = r_built;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_rank      = r_rank;
        n_leg       = r_leg;
        n_step      = r_step;
        n_col_leg   = r_col_leg;
        n_fwd       = r_fwd;
        n_mcnt      = r_mcnt;
        n_xm        = r_xm;
        n_ym        = r_ym;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd_ready = 1'b0;
        w_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.mode == odss_pkg::MODE_REBUILD) begin
                        // walk starts at the centre, one step back on even sides
                        n_side    = w_clamp;
                        n_col     = IW'(w_clamp >> 1);
                        n_row     = IW'(w_clamp >> 1) - {{(IW-1){1'b0}}, ~w_clamp[0]};
                        n_k       = '0;
                        n_rank    = EW'(1);
                        n_leg     = SW'(1);
                        n_step    = '0;
                        n_col_leg = 1'b0;
                        n_fwd     = 1'b1;
                        n_state   = S_WALK;
                    end else begin
                        n_mcnt  = '0;
                        n_xm    = '0;
                        n_ym    = '0;
                        n_state = S_MOD;
                    end
                end
            end
            S_WALK: begin
                w_we = 1'b1;
                if (r_k == w_last) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k    = r_k + AW'(1);
                    // odd ranks first, then even ranks from 2
                    n_rank = (r_k == w_half_m1) ? EW'(2) : r_rank + EW'(2);
                    if (!r_col_leg) begin
                        n_row = r_fwd ? r_row + IW'(1) : r_row - IW'(1);
                    end else begin
                        n_col = r_fwd ? r_col - IW'(1) : r_col + IW'(1);
                    end
                    if (r_step == r_leg - SW'(1)) begin
                        n_step    = '0;
                        n_col_leg = ~r_col_leg;
                        if (r_col_leg) begin
                            n_fwd = ~r_fwd;
                            n_leg = r_leg + SW'(1);
                        end
                    end else begin
                        n_step = r_step + SW'(1);
                    end
                end
            end
            S_MOD: begin
                n_xm = f_mod_nib(r_xm, w_xnib, r_side);
                n_ym = f_mod_nib(r_ym, w_ynib, r_side);
                if (r_mcnt == 2'd2) begin
                    n_state = S_READ;
                end else begin
                    n_mcnt = r_mcnt + 2'd1;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= SW'(1);
            r_built     <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_rank      <= '0;
            r_leg       <= SW'(1);
            r_step      <= '0;
            r_col_leg   <= 1'b0;
            r_fwd       <= 1'b1;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_side      <= n_side;
            r_built     <= n_built;
            r_row       <= n_row;
            r_col       <= n_col;
            r_k         <= n_k;
            r_rank      <= n_rank;
            r_leg       <= n_leg;
            r_step      <= n_step;
            r_col_leg   <= n_col_leg;
            r_fwd       <= n_fwd;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: command, residues, products, result
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_xm  <= n_xm;
        r_ym  <= n_ym;
        if (r_state == S_MOD) begin
            r_prod[0] <= PW'(r_cmd.red)   * PW'(w_scale);
            r_prod[1] <= PW'(r_cmd.green) * PW'(w_scale);
            r_prod[2] <= PW'(r_cmd.blue)  * PW'(w_scale);
        end
        if (w_load) begin
            r_out_user <= r_built;
            r_out_r    <= (r_built && r_prod[0] > w_thr) ? odss_pkg::CH_ON : odss_pkg::CH_OFF;
            r_out_g    <= (r_built && r_prod[1] > w_thr) ? odss_pkg::CH_ON : odss_pkg::CH_OFF;
            r_out_b    <= (r_built && r_prod[2] > w_thr) ? odss_pkg::CH_ON : odss_pkg::CH_OFF;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {r_out_b, r_out_g, r_out_r};
    assign o_m_tuser[0] = r_out_user;

endmodule

>>> hw/rtl/ordered_dither_spiral_screen_unit.sv
// ----------------------------------------------------------------------------
// ordered_dither_spiral_screen_unit: spiral ordered-dither screen
// Builds an n-by-n threshold screen by an outward spiral and thresholds
// RGB pixels against it.
// ----------------------------------------------------------------------------
// Usage:
//  - Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): side n of the screen,
//    0 acts as 1, above 16 acts as 16. Write only while the unit is idle.
//  - Input stream: tuser = mode. Mode 0 rebuilds the screen from the current
//    side and yields no output beat; mode 1 dithers one pixel and yields
//    exactly one output beat.
//  - Output stream: each channel is 0 or 255, tuser says whether a screen
//    had been built before that pixel (all zero if not).
//  - A pixel passes through the back end in order: queue pop, three 4-bit
//    modulo steps, RAM read, compare. The back end takes the next command
//    only once the result is loaded into the output register.
//  - A rebuild holds the back end for the whole walk, one RAM write per cell.
//  - A two-entry command queue sits between the input side and the back end,
//    so up to two input beats are still taken while the back end is busy or
//    its output register waits on m_axis_tready.
//  - Reset: queue and output emptied, no screen built, side back to 4.
//    Screen RAM contents are not cleared; pixels before a rebuild are
//    answered from the no-screen path.
// ----------------------------------------------------------------------------
module ordered_dither_spiral_screen_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [odss_pkg::SIDE_W-1:0]   i_cfg_data,    // matrix_size
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [11:0] col_x, [23:12] row_y, [31:24] red_in, [39:32] green_in,
    // [47:40] blue_in
    input  logic [odss_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,  // [0] mode
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [odss_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic [0:0]                    m_axis_tuser   // [0] screen_valid
);

    logic [odss_pkg::SIDE_W-1:0] r_matrix_size;
    odss_pkg::t_cmd              w_cmd;
    logic                        w_cmd_valid;
    logic                        w_cmd_ready;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= odss_pkg::SIDE_RESET;
        end else if (i_cfg_valid) begin
            r_matrix_size <= i_cfg_data;
        end
    end

    odss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    odss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_matrix_size (r_matrix_size),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd         (w_cmd),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser)
    );

    // output register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // every channel is fully on or fully off
    a_binary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[7:0]   == 8'h00 || m_axis_tdata[7:0]   == 8'hFF) &&
            (m_axis_tdata[15:8]  == 8'h00 || m_axis_tdata[15:8]  == 8'hFF) &&
            (m_axis_tdata[23:16] == 8'h00 || m_axis_tdata[23:16] == 8'hFF))
        else $error("dithered channel not 0 or 255");

    // no screen built means an all-dark pixel
    a_no_screen_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("pixel lit without a screen");

endmodule

>>> tb/odss_dither_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// odss_dither_checker: scoreboard for the spiral ordered-dither screen
// Watches the config, input and output channels, keeps its own copy of the
// screen and the side, and compares every output beat with the oldest
// predicted pixel.
// ----------------------------------------------------------------------------
module odss_dither_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [odss_pkg::SIDE_W-1:0]   i_cfg_data,
    input  logic                          i_in_tvalid,
    input  logic                          i_in_tready,
    input  logic [odss_pkg::IN_W-1:0]     i_in_tdata,
    input  logic [0:0]                    i_in_tuser,
    input  logic                          i_out_tvalid,
    input  logic                          i_out_tready,
    input  logic [odss_pkg::OUT_W-1:0]    i_out_tdata,
    input  logic [0:0]                    i_out_tuser,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_pixels_checked,
    output int                            o_rebuilds
);

    localparam int CW   = odss_pkg::COORD_W;
    localparam int HW   = odss_pkg::CH_W;
    localparam int EW   = odss_pkg::ENTRY_W;
    localparam int MAXS = odss_pkg::MAX_SIDE;

    typedef struct packed {
        logic [HW-1:0] red;
        logic [HW-1:0] green;
        logic [HW-1:0] blue;
        logic          screen_valid;
    } t_pixel_result;

    logic [EW-1:0]                screen_ranks [odss_pkg::DEPTH];
    logic [odss_pkg::SIDE_W-1:0]  side_reg;
    int                           built_side;
    bit                           screen_built;
    t_pixel_result                expected_pixels [$];
    odss_pkg::t_cmd               cmd;
    t_pixel_result                want;
    t_pixel_result                got;

    // rank of walk cell k: odd ranks for the first half, even ranks after
    function automatic void put_rank(int c, int r, int k, int half);
        int rank;
        rank = (k < half) ? 2 * k + 1 : 2 * (k - half) + 2;
        if (c >= 0 && c < MAXS && r >= 0 && r < MAXS)
            screen_ranks[c * MAXS + r] = EW'(rank);
    endfunction

    // outward spiral from the center; legs 1,1,2,2,...; direction flips per pair
    function automatic void lay_spiral(int n);
        int c, r, k, i, leg, total, half;
        bit fwd;
        total = n * n;
        half  = (total + 1) / 2;
        c     = n / 2;
        r     = n / 2 - ((n % 2 == 0) ? 1 : 0);
        leg   = 1;
        fwd   = 1'b1;
        k     = 0;
        put_rank(c, r, k, half);
        k++;
        while (k < total) begin
            for (i = 0; i < leg && k < total; i++) begin
                r = fwd ? r + 1 : r - 1;
                put_rank(c, r, k, half);
                k++;
            end
            for (i = 0; i < leg && k < total; i++) begin
                c = fwd ? c - 1 : c + 1;
                put_rank(c, r, k, half);
                k++;
            end
            fwd = !fwd;
            leg++;
        end
        built_side   = n;
        screen_built = 1'b1;
    endfunction

    // threshold: channel on when c * (n*n+1) > entry * 256
    function automatic t_pixel_result dither_pixel(odss_pkg::t_cmd px);
        t_pixel_result res;
        int e, scale, thr;
        res = '0;
        if (!screen_built)
            return res;
        e     = screen_ranks[(int'(px.col_x) % built_side) * MAXS
                             + (int'(px.row_y) % built_side)];
        scale = built_side * built_side + 1;
        thr   = e * 256;
        res.red   = (int'(px.red)   * scale > thr) ? odss_pkg::CH_ON : odss_pkg::CH_OFF;
        res.green = (int'(px.green) * scale > thr) ? odss_pkg::CH_ON : odss_pkg::CH_OFF;
        res.blue  = (int'(px.blue)  * scale > thr) ? odss_pkg::CH_ON : odss_pkg::CH_OFF;
        res.screen_valid = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_reg     = odss_pkg::SIDE_RESET;
            screen_built = 1'b0;
            built_side   = 1;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                side_reg = i_cfg_data;

            if (i_in_tvalid && i_in_tready) begin
                cmd.mode  = i_in_tuser[0];
                cmd.col_x = i_in_tdata[0 +: CW];
                cmd.row_y = i_in_tdata[CW +: CW];
                cmd.red   = i_in_tdata[2 * CW +: HW];
                cmd.green = i_in_tdata[2 * CW + HW +: HW];
                cmd.blue  = i_in_tdata[2 * CW + 2 * HW +: HW];
                if (cmd.mode == odss_pkg::MODE_REBUILD) begin
                    lay_spiral((side_reg == 0) ? 1 :
                               (side_reg > MAXS) ? MAXS : int'(side_reg));
                    o_rebuilds++;
                end else begin
                    expected_pixels.push_back(dither_pixel(cmd));
                end
            end

            if (i_out_tvalid && i_out_tready) begin
                got.red          = i_out_tdata[0 +: HW];
                got.green        = i_out_tdata[HW +: HW];
                got.blue         = i_out_tdata[2 * HW +: HW];
                got.screen_valid = i_out_tuser[0];
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] unexpected output beat r=%0d g=%0d b=%0d v=%0b",
                                 $time, got.red, got.green, got.blue, got.screen_valid);
                end else begin
                    want = expected_pixels.pop_front();
                    o_pixels_checked++;
                    if (got.red != want.red || got.green != want.green ||
                        got.blue != want.blue || got.screen_valid != want.screen_valid)
                    begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] pixel mismatch: exp r=%0d g=%0d b=%0d v=%0b,",
                                      " got r=%0d g=%0d b=%0d v=%0b"},
                                     $time, want.red, want.green, want.blue,
                                     want.screen_valid, got.red, got.green, got.blue,
                                     got.screen_valid);
                    end
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

>>> tb/ordered_dither_spiral_screen_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_dither_spiral_screen_unit_tb: stream test of the dither screen unit
// Directed beats for pre-build pixels, coordinate and channel extremes and
// out-of-range sides, then random phases of side write, rebuild and pixel
// bursts under random backpressure. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module ordered_dither_spiral_screen_unit_tb;

    localparam int CW           = odss_pkg::COORD_W;
    localparam int HW           = odss_pkg::CH_W;
    localparam int SW           = odss_pkg::SIDE_W;
    localparam int MAXS         = odss_pkg::MAX_SIDE;
    localparam int ITEM_TARGET  = 1550;
    localparam int IDLE_PCT     = 34;       // chance of an idle cycle per side
    localparam int DRAIN_CYCLES = 900;      // room for three queued rebuilds at n=16
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int CYCLE_LIMIT  = 600000;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [SW-1:0]                 i_cfg_data    = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [odss_pkg::IN_W-1:0]     s_axis_tdata  = '0;
    logic [0:0]                    s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [odss_pkg::OUT_W-1:0]    m_axis_tdata;
    logic [0:0]                    m_axis_tuser;

    int                  fail_count;
    int                  pending;
    int                  pixels_checked;
    int                  rebuilds;

    int                  items_sent    = 0;
    int                  phase         = 0;
    int                  side_written  = int'(odss_pkg::SIDE_RESET);
    int                  built_n       = 1;     // side the last rebuild used
    bit                  quiet         = 1'b0;  // no idling on either side
    int                  beats_seen    = 0;
    int                  hold_left     = 0;
    int                  cycle_count   = 0;

    always #4 i_clk = ~i_clk;

    ordered_dither_spiral_screen_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    odss_dither_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_tvalid      (s_axis_tvalid),
        .i_in_tready      (s_axis_tready),
        .i_in_tdata       (s_axis_tdata),
        .i_in_tuser       (s_axis_tuser),
        .i_out_tvalid     (m_axis_tvalid),
        .i_out_tready     (m_axis_tready),
        .i_out_tdata      (m_axis_tdata),
        .i_out_tuser      (m_axis_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_pixels_checked (pixels_checked),
        .o_rebuilds       (rebuilds)
    );

    // Run limit: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: random tready, none while quiet. Two long hold-offs start
    // on fixed input beat counts; the sender keeps offering meanwhile, so the
    // command queue and output register fill and s_axis_tready drops.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            beats_seen <= beats_seen + 1;
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (s_axis_tvalid && s_axis_tready &&
                     (beats_seen == 300 || beats_seen == 1000)) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // One input beat. Random idle cycles ahead of it, then tvalid held until
    // the handshake. Returns aligned to the accepting edge with tvalid high.
    task automatic send_beat(input logic mode, input logic [CW-1:0] x,
                             input logic [CW-1:0] y, input logic [HW-1:0] r,
                             input logic [HW-1:0] g, input logic [HW-1:0] b);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {b, g, r, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (mode == odss_pkg::MODE_REBUILD)
            built_n = (side_written == 0) ? 1 :
                      (side_written > MAXS) ? MAXS : side_written;
    endtask

    // Rebuild beat; the data bits are don't-care, so they are random.
    task automatic send_rebuild();
        send_beat(odss_pkg::MODE_REBUILD, CW'($urandom), CW'($urandom),
                  HW'($urandom), HW'($urandom), HW'($urandom));
    endtask

    // Random pixel. Coordinates now and then at the extremes; about half the
    // channels land right at a threshold of the current screen, so both
    // sides of the compare get hit.
    task automatic send_pixel();
        logic [CW-1:0] x, y;
        logic [HW-1:0] chan [3];
        int            n2, rank, v, j;
        n2 = built_n * built_n;
        x  = CW'($urandom);
        y  = CW'($urandom);
        if ($urandom_range(0, 3) == 0)
            x = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 3) == 0)
            y = $urandom_range(0, 1) ? '1 : '0;
        for (j = 0; j < 3; j++) begin
            if ($urandom_range(0, 1)) begin
                chan[j] = HW'($urandom);
            end else begin
                rank    = $urandom_range(1, n2);
                v       = rank * 256 / (n2 + 1) + $urandom_range(0, 1);
                chan[j] = (v > 255) ? odss_pkg::CH_ON : HW'(v);
            end
        end
        send_beat(odss_pkg::MODE_PIXEL, x, y, chan[0], chan[1], chan[2]);
    endtask

    // Drop tvalid, wait for all results, then let queued rebuilds that produce
    // no beat run out before anything touches the side register.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [SW-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        side_written  = v;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // no screen yet: every pixel answers all zero
        send_beat(odss_pkg::MODE_PIXEL, '0, '0,
                  odss_pkg::CH_OFF, odss_pkg::CH_OFF, odss_pkg::CH_OFF);
        send_beat(odss_pkg::MODE_PIXEL, '1, '1,
                  odss_pkg::CH_ON, odss_pkg::CH_ON, odss_pkg::CH_ON);
        send_beat(odss_pkg::MODE_PIXEL, 12'hA5A, 12'h5A5, 8'h80, 8'h01, 8'hFE);

        // first build uses the reset side of 4
        send_rebuild();
        send_beat(odss_pkg::MODE_PIXEL, '0, '0,
                  odss_pkg::CH_ON, odss_pkg::CH_ON, odss_pkg::CH_ON);
        send_beat(odss_pkg::MODE_PIXEL, '0, '0,
                  odss_pkg::CH_OFF, odss_pkg::CH_OFF, odss_pkg::CH_OFF);
        send_beat(odss_pkg::MODE_PIXEL, '1, '1, 8'h01, 8'hFE, 8'h80);
        repeat (4) send_pixel();

        // side written as 0 after a build: pixels still use side 4
        wait_idle();
        write_side(5'd0);
        repeat (3) send_pixel();
        send_rebuild();                 // now side 0 acts as 1
        repeat (2) send_pixel();

        // above the largest side: acts as 16
        wait_idle();
        write_side(5'd31);
        send_rebuild();
        repeat (2) send_pixel();

        // ---- random phases ----
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            phase++;
            quiet <= (phase >= 6 && phase <= 8);
            case (phase)
                1:       write_side(5'd16);
                2:       write_side(5'd17);
                3:       write_side(5'd1);
                4:       write_side(5'd2);
                5:       write_side(5'd15);
                default: write_side($urandom_range(0, 99) < 70 ?
                                    SW'($urandom_range(1, 8)) :
                                    SW'($urandom_range(0, 31)));
            endcase
            // sometimes pixels before the rebuild, on the stale side
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) send_pixel();
            send_rebuild();
            repeat ($urandom_range(30, 90)) begin
                if ($urandom_range(0, 99) < 8)
                    send_rebuild();
                else
                    send_pixel();
            end
        end

        wait_idle();
        $display("Ran %0d input beats: %0d pixel results checked, %0d rebuilds, %0d side phases",
                 items_sent, pixels_checked, rebuilds, phase + 3);
        $display("Covered pixels before any build, stale side after a write, sides 0..31 "
                 , "and long output hold-offs");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d failures, %0d results missing", fail_count, pending);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/odss_pkg.sv
hw/rtl/odss_ram.sv
hw/rtl/odss_front.sv
hw/rtl/odss_back.sv
hw/rtl/ordered_dither_spiral_screen_unit.sv
tb/odss_dither_checker.sv
tb/ordered_dither_spiral_screen_unit_tb.sv
